// File: rtl/core/multichannel_dma_controller_macros.svh
// assertion macros used by the dma controller checker
`ifndef MULTICHANNEL_DMA_CONTROLLER_MACROS_SVH
`define MULTICHANNEL_DMA_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MDMAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MDMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that is also checked across reset
`define MDMAC_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/mdmac_pkg.sv
// shared types and codes of the dma controller
`default_nettype none
package mdmac_pkg;

  // command codes carried in tuser
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_HDMA  = 3'd4;

  // register index within a channel
  localparam logic [3:0] REG_CTL     = 4'h0;
  localparam logic [3:0] REG_BBASE   = 4'h1;
  localparam logic [3:0] REG_AOFF_LO = 4'h2;
  localparam logic [3:0] REG_AOFF_HI = 4'h3;
  localparam logic [3:0] REG_ABANK   = 4'h4;
  localparam logic [3:0] REG_CNT_LO  = 4'h5;
  localparam logic [3:0] REG_CNT_HI  = 4'h6;
  localparam logic [3:0] REG_IBANK   = 4'h7;
  localparam logic [3:0] REG_TOFF_LO = 4'h8;
  localparam logic [3:0] REG_TOFF_HI = 4'h9;
  localparam logic [3:0] REG_REPEAT  = 4'ha;
  localparam logic [3:0] REG_SPARE   = 4'hb;
  localparam logic [3:0] REG_SPARE2  = 4'hf;

  // cost timer amounts
  localparam logic [7:0] COST_START = 8'd16;
  localparam logic [7:0] COST_BYTE  = 8'd6;
  localparam logic [7:0] COST_LAST  = 8'd14;
  localparam logic [7:0] TICK_STEP  = 8'd2;

  // scheduler to register file: which channel is served this item
  typedef struct packed {
    logic       serve;
    logic [2:0] ch;
  } serve_t;

  // register file to scheduler and top: the served channel's transfer
  typedef struct packed {
    logic [23:0] a_address;
    logic [7:0]  b_address;
    logic        from_b;
    logic        last;
  } xfer_t;

endpackage
`default_nettype wire

// File: rtl/core/mdmac_regfile.sv
// per-channel register file with host access and per-transfer update
`default_nettype none
module mdmac_regfile #(
  parameter int CHANNELS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire logic [6:0]      reg_address,
  input  wire logic [7:0]      write_data,
  input  wire mdmac_pkg::serve_t srv,
  output logic [7:0]           rd_data,
  output mdmac_pkg::xfer_t     xfer
);

  typedef struct packed {
    logic [7:0]  ctl;
    logic [7:0]  bbase;
    logic [15:0] aoff;
    logic [7:0]  abank;
    logic [15:0] cnt;
    logic [7:0]  ibank;
    logic [15:0] toff;
    logic [7:0]  rep;
    logic [7:0]  spare;
    logic [1:0]  step;
  } ch_state_t;

  localparam ch_state_t CH_RST = '{
    ctl: 8'hff, bbase: 8'hff, aoff: 16'hffff, abank: 8'hff, cnt: 16'hffff,
    ibank: 8'hff, toff: 16'hffff, rep: 8'hff, spare: 8'hff, step: 2'd0
  };

  // b-bus offset per mode, four 2-bit entries per mode, step 0 lowest
  localparam logic [7:0][7:0] MODE_OFS = {
    8'h50, 8'h00, 8'h44, 8'he4, 8'h50, 8'h00, 8'h44, 8'h00
  };

  logic [2:0] acc_ch;
  logic [3:0] reg_idx;
  logic [7:0] rd_byte [CHANNELS];
  mdmac_pkg::xfer_t ch_xfer [CHANNELS];

  assign acc_ch  = reg_address[6:4];
  assign reg_idx = reg_address[3:0];

  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    ch_state_t  st_r;
    ch_state_t  st_nxt;
    logic [1:0] ofs;

    assign ofs = MODE_OFS[st_r.ctl[2:0]][{st_r.step, 1'b0} +: 2];

    always_comb begin
      st_nxt = st_r;
      if (wr_en && acc_ch == 3'(i)) begin
        case (reg_idx)
          mdmac_pkg::REG_CTL:     st_nxt.ctl = write_data;
          mdmac_pkg::REG_BBASE:   st_nxt.bbase = write_data;
          mdmac_pkg::REG_AOFF_LO: st_nxt.aoff[7:0] = write_data;
          mdmac_pkg::REG_AOFF_HI: st_nxt.aoff[15:8] = write_data;
          mdmac_pkg::REG_ABANK:   st_nxt.abank = write_data;
          mdmac_pkg::REG_CNT_LO:  st_nxt.cnt[7:0] = write_data;
          mdmac_pkg::REG_CNT_HI:  st_nxt.cnt[15:8] = write_data;
          mdmac_pkg::REG_IBANK:   st_nxt.ibank = write_data;
          mdmac_pkg::REG_TOFF_LO: st_nxt.toff[7:0] = write_data;
          mdmac_pkg::REG_TOFF_HI: st_nxt.toff[15:8] = write_data;
          mdmac_pkg::REG_REPEAT:  st_nxt.rep = write_data;
          mdmac_pkg::REG_SPARE,
          mdmac_pkg::REG_SPARE2:  st_nxt.spare = write_data;
          default: ;
        endcase
      end
      if (srv.serve && srv.ch == 3'(i)) begin
        st_nxt.step = (st_r.cnt == 16'd1) ? 2'd0 : st_r.step + 2'd1;
        if (!st_r.ctl[3]) begin
          st_nxt.aoff = st_r.ctl[4] ? st_r.aoff - 16'd1 : st_r.aoff + 16'd1;
        end
        // zero count wraps, so a count of zero runs 65536 bytes
        st_nxt.cnt = st_r.cnt - 16'd1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r <= CH_RST;
      end else begin
        st_r <= st_nxt;
      end
    end

    always_comb begin
      case (reg_idx)
        mdmac_pkg::REG_CTL:     rd_byte[i] = st_r.ctl;
        mdmac_pkg::REG_BBASE:   rd_byte[i] = st_r.bbase;
        mdmac_pkg::REG_AOFF_LO: rd_byte[i] = st_r.aoff[7:0];
        mdmac_pkg::REG_AOFF_HI: rd_byte[i] = st_r.aoff[15:8];
        mdmac_pkg::REG_ABANK:   rd_byte[i] = st_r.abank;
        mdmac_pkg::REG_CNT_LO:  rd_byte[i] = st_r.cnt[7:0];
        mdmac_pkg::REG_CNT_HI:  rd_byte[i] = st_r.cnt[15:8];
        mdmac_pkg::REG_IBANK:   rd_byte[i] = st_r.ibank;
        mdmac_pkg::REG_TOFF_LO: rd_byte[i] = st_r.toff[7:0];
        mdmac_pkg::REG_TOFF_HI: rd_byte[i] = st_r.toff[15:8];
        mdmac_pkg::REG_REPEAT:  rd_byte[i] = st_r.rep;
        mdmac_pkg::REG_SPARE,
        mdmac_pkg::REG_SPARE2:  rd_byte[i] = st_r.spare;
        default:                rd_byte[i] = 8'h00;
      endcase
    end

    assign ch_xfer[i] = '{
      a_address: {st_r.abank, st_r.aoff},
      b_address: st_r.bbase + {6'd0, ofs},
      from_b:    st_r.ctl[7],
      last:      st_r.cnt == 16'd1
    };
  end

  // channels past CHANNELS never match and read as zero
  always_comb begin
    rd_data = 8'h00;
    xfer    = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (acc_ch == 3'(i)) begin
        rd_data = rd_byte[i];
      end
      if (srv.ch == 3'(i)) begin
        xfer = ch_xfer[i];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mdmac_sched.sv
// busy flag, cost timer, active mask and channel priority pick
`default_nettype none
module mdmac_sched #(
  parameter int CHANNELS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [2:0]       cmd,
  input  wire logic [7:0]       write_data,
  input  wire logic             last,
  output mdmac_pkg::serve_t     srv,
  output logic                  busy_nxt
);

  logic [7:0]          timer_r;
  logic [7:0]          timer_nxt;
  logic                busy_r;
  logic [CHANNELS-1:0] active_r;
  logic [CHANNELS-1:0] active_nxt;
  logic [CHANNELS-1:0] mask;
  logic [8:0]          start_sum;
  logic [2:0]          pick;

  assign mask      = write_data[CHANNELS-1:0];
  assign start_sum = {1'b0, timer_r} + {1'b0, mdmac_pkg::COST_START};

  // lowest-numbered active channel wins
  always_comb begin
    pick = 3'd0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (active_r[i]) begin
        pick = 3'(i);
      end
    end
  end

  always_comb begin
    timer_nxt  = timer_r;
    busy_nxt   = busy_r;
    active_nxt = active_r;
    srv        = '{serve: 1'b0, ch: pick};
    if (go) begin
      case (cmd)
        mdmac_pkg::CMD_START: begin
          active_nxt = mask;
          busy_nxt   = |mask;
          if (|mask) begin
            timer_nxt = start_sum[8] ? 8'hff : start_sum[7:0];
          end
        end
        mdmac_pkg::CMD_TICK: begin
          if (busy_r) begin
            if (timer_r != 8'd0) begin
              timer_nxt = (timer_r >= mdmac_pkg::TICK_STEP) ?
                          timer_r - mdmac_pkg::TICK_STEP : 8'd0;
            end else if (|active_r) begin
              srv.serve = 1'b1;
              // timer is zero here, so the added cost never saturates
              timer_nxt = last ? mdmac_pkg::COST_LAST : mdmac_pkg::COST_BYTE;
              if (last) begin
                active_nxt[pick] = 1'b0;
              end
            end else begin
              busy_nxt = 1'b0;
            end
          end
        end
        // hdma enables have no effect without an hdma engine
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= 8'd0;
      busy_r   <= 1'b0;
      active_r <= '0;
    end else begin
      timer_r  <= timer_nxt;
      busy_r   <= busy_nxt;
      active_r <= active_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/multichannel_dma_controller.sv
// eight-channel general-purpose dma controller, top level
//
// channel  | tdata                                         | tuser
// in_      | 6:0 reg_address, 14:7 write_data              | 2:0 cmd
// out_     | 7:0 read_data, 10:8 transfer_channel,         | 0 transfer_valid
//          | 34:11 a_address, 42:35 b_address, 43 from_b,  |
//          | 44 busy_res                                   |
//
// one item per cycle while the result is not held; input register, then one pass of
// register-file and scheduler logic into the result register
// synchronous active-low reset clears both stages, the scheduler and sets
// every channel register to its power-on value
// a held result stalls the pass; the input register still takes one item
`default_nettype none
module multichannel_dma_controller #(
  parameter int CHANNELS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // 6:0 reg_address, 14:7 write_data
  input  wire logic [2:0]  in_tuser,   // 2:0 cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // 7:0 read_data, 10:8 transfer_channel,
                                       // 34:11 a_address, 42:35 b_address,
                                       // 43 from_b, 44 busy_res
  output logic [0:0]       out_tuser   // 0 transfer_valid
);

  logic        in_vld_r;
  logic [2:0]  cmd_r;
  logic [6:0]  addr_r;
  logic [7:0]  wd_r;
  logic        out_vld_r;
  logic [47:0] out_data_r;
  logic [0:0]  out_user_r;
  logic        go;
  logic        busy_nxt;
  logic [7:0]  rd_data;
  logic [47:0] out_data_nxt;

  mdmac_pkg::serve_t srv;
  mdmac_pkg::xfer_t  xfer;

  assign go        = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || go;

  mdmac_regfile #(
    .CHANNELS(CHANNELS)
  ) u_regfile (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (go && cmd_r == mdmac_pkg::CMD_WRITE),
    .reg_address(addr_r),
    .write_data (wd_r),
    .srv        (srv),
    .rd_data    (rd_data),
    .xfer       (xfer)
  );

  mdmac_sched #(
    .CHANNELS(CHANNELS)
  ) u_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .cmd       (cmd_r),
    .write_data(wd_r),
    .last      (xfer.last),
    .srv       (srv),
    .busy_nxt  (busy_nxt)
  );

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[44]    = busy_nxt;
    if (cmd_r == mdmac_pkg::CMD_READ) begin
      out_data_nxt[7:0] = rd_data;
    end
    if (srv.serve) begin
      out_data_nxt[10:8]  = srv.ch;
      out_data_nxt[34:11] = xfer.a_address;
      out_data_nxt[42:35] = xfer.b_address;
      out_data_nxt[43]    = xfer.from_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (go) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (in_tready && in_tvalid) begin
      cmd_r  <= in_tuser;
      addr_r <= in_tdata[6:0];
      wd_r   <= in_tdata[14:7];
    end
    if (go) begin
      out_data_r <= out_data_nxt;
      out_user_r <= srv.serve;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// File: rtl/core/mdmac_checker.sv
// port-level checks of the dma controller, bound to the top level
`default_nettype none
`include "multichannel_dma_controller_macros.svh"
module mdmac_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // a stalled result holds still
  `MDMAC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // without a transfer every transfer field is zero
  `MDMAC_ASSERT_NOW(a_idle_fields, clk, rst_n, out_tvalid && !out_tuser[0],
    out_tdata[43:8] == 36'd0)

  // a transfer leaves the controller busy and carries no read byte
  `MDMAC_ASSERT_NOW(a_xfer_busy, clk, rst_n, out_tvalid && out_tuser[0],
    out_tdata[44] && out_tdata[7:0] == 8'd0)

  // an empty result register never blocks the input
  `MDMAC_ASSERT_NOW(a_in_ready, clk, rst_n, !out_tvalid, in_tready)

  // reset empties the result register
  `MDMAC_ASSERT_RST(a_rst_empty, clk, !rst_n, !out_tvalid)

endmodule

bind multichannel_dma_controller mdmac_checker u_mdmac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire
